### hw/rtl/lsid_pkg.sv
// ----------------------------------------------------------------------------
// lsid_pkg: shared definitions for the list set intersection/difference block
// Operation codes, field widths and the controller/datapath command and
// status types.
// ----------------------------------------------------------------------------
package lsid_pkg;

   localparam int LIST_DEPTH_DEF = 8;
   localparam int KEY_W          = 16;
   localparam int OP_W           = 3;

   localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
   localparam logic [OP_W-1:0] OP_LIST_B    = 3'd1;
   localparam logic [OP_W-1:0] OP_LIST_V    = 3'd2;
   localparam logic [OP_W-1:0] OP_PAIRS     = 3'd3;
   localparam logic [OP_W-1:0] OP_B_MINUS_V = 3'd4;
   localparam logic [OP_W-1:0] OP_V_MINUS_B = 3'd5;
   localparam logic [OP_W-1:0] OP_LIST_N    = 3'd6;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_INSERT,
      CMD_STEP,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_end;
      logic req_is_insert;
   } stat_type;

endpackage

### hw/rtl/lsid_if.sv
// ----------------------------------------------------------------------------
// lsid_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface lsid_req_if import lsid_pkg::*;;
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] op;
   logic [KEY_W-1:0] roll;
   logic            likes_b;
   logic            likes_v;

   modport source (output valid, op, roll, likes_b, likes_v, input ready);
   modport sink   (input valid, op, roll, likes_b, likes_v, output ready);
endinterface

interface lsid_rsp_if import lsid_pkg::*;;
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] value;
   logic             has_value;
   logic             final_flag;
   logic             full_res;

   modport source (output valid, value, has_value, final_flag, full_res, input ready);
   modport sink   (input valid, value, has_value, final_flag, full_res, output ready);
endinterface

### hw/rtl/lsid_ctrl.sv
// ----------------------------------------------------------------------------
// lsid_ctrl: sequencing state machine
// Accepts one request word at a time and steps the datapath through the
// insert, scan and final-result phases.
// ----------------------------------------------------------------------------
module lsid_ctrl import lsid_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_INSERT = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = stat.req_is_insert ? ST_INSERT : ST_SCAN;
            end
         end
         ST_INSERT: begin
            if (stat.out_free) begin
               cmd      = CMD_INSERT;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // The datapath holds its position by itself when a hit cannot
            // be passed on yet.
            if (stat.scan_end) begin
               state_in = ST_FINISH;
            end else begin
               cmd = CMD_STEP;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd      = CMD_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/lsid_datapath.sv
// ----------------------------------------------------------------------------
// lsid_datapath: key lists, scan indexes and response register
// Holds the three lists, runs one compare step per command and keeps the
// most recent hit back until it is known whether it is the last one.
// ----------------------------------------------------------------------------
module lsid_datapath import lsid_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [OP_W-1:0]  req_op,
   input  logic [KEY_W-1:0] req_roll,
   input  logic             req_likes_b,
   input  logic             req_likes_v,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [KEY_W-1:0] rsp_value,
   output logic             rsp_has_value,
   output logic             rsp_final_flag,
   output logic             rsp_full_res
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

   typedef enum logic [1:0] {
      MODE_LIST,
      MODE_PAIRS,
      MODE_MINUS,
      MODE_NONE
   } mode_type;

   // List storage (written only at the fill count, while it is below the depth).
   logic [KEY_W-1:0] b_mem_ff [LIST_DEPTH];
   logic [KEY_W-1:0] v_mem_ff [LIST_DEPTH];
   logic [KEY_W-1:0] n_mem_ff [LIST_DEPTH];
   logic [CNT_W-1:0] b_cnt_ff, b_cnt_in;
   logic [CNT_W-1:0] v_cnt_ff, v_cnt_in;
   logic [CNT_W-1:0] n_cnt_ff, n_cnt_in;

   // Latched request.
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             lb_ff, lb_in;
   logic             lv_ff, lv_in;

   // Scan position.
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic             found_ff, found_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [KEY_W-1:0] pend_value_ff, pend_value_in;

   // Response register.
   logic             out_valid_ff, out_valid_in;
   logic [KEY_W-1:0] out_value_ff, out_value_in;
   logic             out_has_ff, out_has_in;
   logic             out_final_ff, out_final_in;
   logic             out_full_ff, out_full_in;

   logic             b_we, v_we, n_we;
   logic             b_drop, v_drop, n_drop;
   logic [IDX_W-1:0] b_raddr, v_raddr;
   logic [KEY_W-1:0] b_rd, v_rd, n_rd;
   mode_type         mode;
   logic [CNT_W-1:0] outer_cnt, inner_cnt;
   logic [KEY_W-1:0] outer_key, inner_key;
   logic [CNT_W-1:0] j_nxt;
   logic             j_valid, keys_eq, inner_last;
   logic             hit, adv_i, blocked, out_free;
   logic             push, push_has, push_final, push_full;
   logic [KEY_W-1:0] push_value;

   assign out_free = !out_valid_ff || rsp_ready;

   // Each list has a single read address.
   assign b_raddr = (op_ff == OP_V_MINUS_B) ? j_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];
   assign v_raddr = (op_ff == OP_V_MINUS_B || op_ff == OP_LIST_V) ?
                    i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];
   assign b_rd = b_mem_ff[b_raddr];
   assign v_rd = v_mem_ff[v_raddr];
   assign n_rd = n_mem_ff[i_ff[IDX_W-1:0]];

   always_comb begin
      mode      = MODE_NONE;
      outer_cnt = '0;
      inner_cnt = '0;
      outer_key = b_rd;
      inner_key = v_rd;
      case (op_ff)
         OP_LIST_B: begin
            mode      = MODE_LIST;
            outer_cnt = b_cnt_ff;
         end
         OP_LIST_V: begin
            mode      = MODE_LIST;
            outer_cnt = v_cnt_ff;
            outer_key = v_rd;
         end
         OP_LIST_N: begin
            mode      = MODE_LIST;
            outer_cnt = n_cnt_ff;
            outer_key = n_rd;
         end
         OP_PAIRS: begin
            mode      = MODE_PAIRS;
            outer_cnt = b_cnt_ff;
            inner_cnt = v_cnt_ff;
         end
         OP_B_MINUS_V: begin
            mode      = MODE_MINUS;
            outer_cnt = b_cnt_ff;
            inner_cnt = v_cnt_ff;
         end
         OP_V_MINUS_B: begin
            mode      = MODE_MINUS;
            outer_cnt = v_cnt_ff;
            inner_cnt = b_cnt_ff;
            outer_key = v_rd;
            inner_key = b_rd;
         end
         default: begin
            mode = MODE_NONE;
         end
      endcase
   end

   assign j_nxt      = j_ff + CNT_W'(1);
   assign j_valid    = j_ff < inner_cnt;
   assign keys_eq    = j_valid && (outer_key == inner_key);
   assign inner_last = (inner_cnt == '0) || (j_nxt == inner_cnt);

   always_comb begin
      hit   = 1'b0;
      adv_i = 1'b1;
      case (mode)
         MODE_LIST: begin
            hit = 1'b1;
         end
         MODE_PAIRS: begin
            hit   = keys_eq;
            adv_i = inner_last;
         end
         MODE_MINUS: begin
            hit   = inner_last && !(found_ff || keys_eq);
            adv_i = inner_last;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign blocked = hit && pend_valid_ff && !out_free;

   // Insert bookkeeping.
   assign b_drop = lb_ff && (b_cnt_ff == DEPTH_CNT);
   assign v_drop = lv_ff && (v_cnt_ff == DEPTH_CNT);
   assign n_drop = !lb_ff && !lv_ff && (n_cnt_ff == DEPTH_CNT);
   assign b_we   = (cmd == CMD_INSERT) && lb_ff && !b_drop;
   assign v_we   = (cmd == CMD_INSERT) && lv_ff && !v_drop;
   assign n_we   = (cmd == CMD_INSERT) && !lb_ff && !lv_ff && !n_drop;
   assign b_cnt_in = b_cnt_ff + CNT_W'(b_we);
   assign v_cnt_in = v_cnt_ff + CNT_W'(v_we);
   assign n_cnt_in = n_cnt_ff + CNT_W'(n_we);

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      lb_in         = lb_ff;
      lv_in         = lv_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      push          = 1'b0;
      push_value    = '0;
      push_has      = 1'b0;
      push_final    = 1'b0;
      push_full     = 1'b0;
      case (cmd)
         CMD_LOAD: begin
            op_in         = req_op;
            key_in        = req_roll;
            lb_in         = req_likes_b;
            lv_in         = req_likes_v;
            i_in          = '0;
            j_in          = '0;
            found_in      = 1'b0;
            pend_valid_in = 1'b0;
         end
         CMD_INSERT: begin
            push       = 1'b1;
            push_final = 1'b1;
            push_full  = b_drop || v_drop || n_drop;
         end
         CMD_STEP: begin
            if (!blocked) begin
               if (hit) begin
                  // The held hit is now known not to be the last one.
                  push          = pend_valid_ff;
                  push_value    = pend_value_ff;
                  push_has      = 1'b1;
                  pend_valid_in = 1'b1;
                  pend_value_in = outer_key;
               end
               if (adv_i) begin
                  i_in     = i_ff + CNT_W'(1);
                  j_in     = '0;
                  found_in = 1'b0;
               end else begin
                  j_in     = j_nxt;
                  found_in = found_ff || keys_eq;
               end
            end
         end
         CMD_FINISH: begin
            // Either the held hit, now marked last, or an empty marker.
            push          = 1'b1;
            push_value    = pend_valid_ff ? pend_value_ff : '0;
            push_has      = pend_valid_ff;
            push_final    = 1'b1;
            pend_valid_in = 1'b0;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign out_valid_in = push || (out_valid_ff && !rsp_ready);
   assign out_value_in = push ? push_value : out_value_ff;
   assign out_has_in   = push ? push_has   : out_has_ff;
   assign out_final_in = push ? push_final : out_final_ff;
   assign out_full_in  = push ? push_full  : out_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_cnt_ff      <= '0;
         v_cnt_ff      <= '0;
         n_cnt_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         b_cnt_ff      <= b_cnt_in;
         v_cnt_ff      <= v_cnt_in;
         n_cnt_ff      <= n_cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lb_ff         <= lb_in;
      lv_ff         <= lv_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      found_ff      <= found_in;
      pend_value_ff <= pend_value_in;
      out_value_ff  <= out_value_in;
      out_has_ff    <= out_has_in;
      out_final_ff  <= out_final_in;
      out_full_ff   <= out_full_in;
      if (b_we) begin
         b_mem_ff[b_cnt_ff[IDX_W-1:0]] <= key_ff;
      end
      if (v_we) begin
         v_mem_ff[v_cnt_ff[IDX_W-1:0]] <= key_ff;
      end
      if (n_we) begin
         n_mem_ff[n_cnt_ff[IDX_W-1:0]] <= key_ff;
      end
   end

   assign stat.out_free      = out_free;
   assign stat.scan_end      = i_ff >= outer_cnt;
   assign stat.req_is_insert = req_op == OP_INSERT;

   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_has_value  = out_has_ff;
   assign rsp_final_flag = out_final_ff;
   assign rsp_full_res   = out_full_ff;

endmodule

### hw/rtl/list_set_intersection_difference_top.sv
// ----------------------------------------------------------------------------
// list_set_intersection_difference_top: key lists with set queries
// Keeps set B, set V and a list of keys in neither, and answers list,
// intersection-pair and difference queries one request word at a time.
// ----------------------------------------------------------------------------
// Usage:
// A request word on req_chan carries op, roll, likes_b and likes_v. An insert
// (op 0) appends roll to B and/or V, or to the neither list when both flags
// are clear, and answers with one acknowledge word whose full_res bit tells
// that a full target list dropped the key. A query answers with a run of
// words that carry keys, the last one with final_flag set, or with one empty
// marker word (has_value clear, final_flag set) when nothing matches.
// Only one request word is in progress at a time. An insert waits until the
// output register is free, then writes its list and places its acknowledge
// there. A query takes one compare step per cycle while the output does not
// stall it: a list query steps once per entry, the pair and difference
// queries once per (outer entry, inner entry) combination, so at most
// LIST_DEPTH * LIST_DEPTH steps. The datapath has a single compare unit,
// which reads one B and one V entry per cycle.
// Results sit in an output register; a new request is taken while the last
// word of the previous one still waits there. When rsp_chan stalls, the scan
// holds its position once it has a further key ready, so nothing is lost.
// Synchronous reset empties all three lists and returns the block to idle.
// ----------------------------------------------------------------------------
module list_set_intersection_difference_top import lsid_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lsid_req_if.sink   req_chan,
   lsid_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences one request word at a time.
   lsid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the lists, the scan indexes and the response register.
   lsid_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_chan.op),
      .req_roll       (req_chan.roll),
      .req_likes_b    (req_chan.likes_b),
      .req_likes_v    (req_chan.likes_v),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_value      (rsp_chan.value),
      .rsp_has_value  (rsp_chan.has_value),
      .rsp_final_flag (rsp_chan.final_flag),
      .rsp_full_res   (rsp_chan.full_res)
   );

endmodule

### hw/rtl/lsid_checker.sv
// ----------------------------------------------------------------------------
// lsid_checker: port-level checks
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module lsid_checker import lsid_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [KEY_W-1:0] rsp_value,
   input logic             rsp_has_value,
   input logic             rsp_final_flag,
   input logic             rsp_full_res
);

   // A stalled response word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_has_value) && $stable(rsp_final_flag) && $stable(rsp_full_res))
      else $error("response word changed while stalled");

   // A word without a key carries a zero value.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_value |-> rsp_value == '0)
      else $error("keyless response word with nonzero value");

   // Acknowledges and empty markers always close their request.
   a_marker_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_value |-> rsp_final_flag)
      else $error("keyless response word not marked final");

   // A dropped insert is reported only on its acknowledge.
   a_full_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> !rsp_has_value && rsp_final_flag)
      else $error("full flag on a word that is not an acknowledge");

   // Requests are taken one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in two consecutive cycles");

endmodule

bind list_set_intersection_difference_top lsid_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_value      (rsp_chan.value),
   .rsp_has_value  (rsp_chan.has_value),
   .rsp_final_flag (rsp_chan.final_flag),
   .rsp_full_res   (rsp_chan.full_res)
);

### tb/sv/list_set_intersection_difference_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_set_intersection_difference_top_tb: self-checking bench for the key lists
// Sends insert and query words with random pacing on both channels.
// A behavioral copy of the three lists predicts every response word,
// which is compared field by field as it arrives.
// ----------------------------------------------------------------------------
module list_set_intersection_difference_top_tb import lsid_pkg::*;;

   localparam int LIST_DEPTH = LIST_DEPTH_DEF;
   // The op field has one code that the block answers with an empty marker.
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   // Generous bound: every word with its longest gap and every result stalled.
   localparam int TIMEOUT_NS = 10_000_000;
   localparam int POOL_SIZE  = 5;

   // One response word as the block should present it.
   typedef struct {
      logic [KEY_W-1:0] value;
      logic             has_value;
      logic             final_flag;
      logic             full_res;
   } rsp_word_t;

   logic clock;
   logic reset;

   lsid_req_if req_chan ();
   lsid_rsp_if rsp_chan ();

   list_set_intersection_difference_top #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the three lists, updated as each request word is accepted.
   logic [KEY_W-1:0] b_keys [LIST_DEPTH];
   logic [KEY_W-1:0] v_keys [LIST_DEPTH];
   logic [KEY_W-1:0] n_keys [LIST_DEPTH];
   int               b_fill;
   int               v_fill;
   int               n_fill;

   // Response words still owed by the block, oldest first.
   rsp_word_t        pending_words [$];

   // Keys reused often so that B and V share entries and pair queries match.
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   // Pacing controls shared by the sender, the receiver and the tests.
   logic tx_idle_on;
   logic rx_idle_on;
   int   rx_hold_cycles;

   int mismatch_count;
   int sent_words;
   int checked_words;
   int drop_count;
   int op_seen [8];

   // The clock runs with a 4 ns period, low first.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Works out the response words of one accepted request word. An insert
   // always gets one acknowledge; a query gets its run of keys with the last
   // one marked, or a single empty marker when the run is empty.
   task automatic predict_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] roll,
                               input logic lb, input logic lv);
      logic [KEY_W-1:0] run_keys [$];
      rsp_word_t        word;
      logic             dropped;
      logic             found;
      dropped = 1'b0;
      if (op == OP_INSERT) begin
         // Each target list takes the key on its own, so a full B does not
         // stop V from taking it; the acknowledge flags any drop.
         if (lb) begin
            if (b_fill == LIST_DEPTH) dropped = 1'b1;
            else begin
               b_keys[b_fill] = roll;
               b_fill++;
            end
         end
         if (lv) begin
            if (v_fill == LIST_DEPTH) dropped = 1'b1;
            else begin
               v_keys[v_fill] = roll;
               v_fill++;
            end
         end
         if (!lb && !lv) begin
            if (n_fill == LIST_DEPTH) dropped = 1'b1;
            else begin
               n_keys[n_fill] = roll;
               n_fill++;
            end
         end
         if (dropped) drop_count++;
         word.value      = '0;
         word.has_value  = 1'b0;
         word.final_flag = 1'b1;
         word.full_res   = dropped;
         pending_words.push_back(word);
      end else begin
         case (op)
            OP_LIST_B: begin
               for (int i = 0; i < b_fill; i++) run_keys.push_back(b_keys[i]);
            end
            OP_LIST_V: begin
               for (int i = 0; i < v_fill; i++) run_keys.push_back(v_keys[i]);
            end
            OP_LIST_N: begin
               for (int i = 0; i < n_fill; i++) run_keys.push_back(n_keys[i]);
            end
            OP_PAIRS: begin
               // B-major, V-minor: a key repeated in either list repeats here.
               for (int i = 0; i < b_fill; i++)
                  for (int j = 0; j < v_fill; j++)
                     if (b_keys[i] == v_keys[j]) run_keys.push_back(b_keys[i]);
            end
            OP_B_MINUS_V: begin
               for (int i = 0; i < b_fill; i++) begin
                  found = 1'b0;
                  for (int j = 0; j < v_fill; j++)
                     if (b_keys[i] == v_keys[j]) found = 1'b1;
                  if (!found) run_keys.push_back(b_keys[i]);
               end
            end
            OP_V_MINUS_B: begin
               for (int i = 0; i < v_fill; i++) begin
                  found = 1'b0;
                  for (int j = 0; j < b_fill; j++)
                     if (v_keys[i] == b_keys[j]) found = 1'b1;
                  if (!found) run_keys.push_back(v_keys[i]);
               end
            end
            default: begin
               // The unused code leaves the run empty.
            end
         endcase
         if (run_keys.size() == 0) begin
            word.value      = '0;
            word.has_value  = 1'b0;
            word.final_flag = 1'b1;
            word.full_res   = 1'b0;
            pending_words.push_back(word);
         end else begin
            foreach (run_keys[i]) begin
               word.value      = run_keys[i];
               word.has_value  = 1'b1;
               word.final_flag = (i == run_keys.size() - 1);
               word.full_res   = 1'b0;
               pending_words.push_back(word);
            end
         end
      end
   endtask

   // Offers one request word after a random gap and holds it until the block
   // takes it. Valid stays high on return, so a following word with no gap
   // goes out back to back; a following call with a gap, or the drain, lowers it.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] roll,
                            input logic lb, input logic lv);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.op      <= op;
      req_chan.roll    <= roll;
      req_chan.likes_b <= lb;
      req_chan.likes_v <= lv;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_word(op, roll, lb, lv);
      sent_words++;
      op_seen[op]++;
   endtask

   // A random word: inserts at the given percentage, mostly with pool keys,
   // and otherwise queries, the unused code being the rarest of them.
   task automatic send_random_word(input int insert_pct);
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] roll;
      int               pick;
      if ($urandom_range(0, 99) < 60) roll = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else roll = KEY_W'($urandom);
      if ($urandom_range(0, 99) < insert_pct) op = OP_INSERT;
      else begin
         // Codes list B through neither get two chances each, the unused code one.
         pick = $urandom_range(2 * OP_LIST_B - 1, 2 * OP_LIST_N + 1);
         op = OP_W'((pick + 1) / 2);
      end
      send_word(op, roll, 1'($urandom), 1'($urandom));
   endtask

   // Lowers valid and waits until every owed response word has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Every query on empty lists answers with one empty marker.
   task automatic test_empty_lists();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_word(OP_LIST_B, 16'h0000, 1'b0, 1'b0);
      send_word(OP_LIST_V, 16'hFFFF, 1'b1, 1'b1);
      send_word(OP_PAIRS, 16'h0000, 1'b1, 1'b0);
      send_word(OP_B_MINUS_V, 16'hFFFF, 1'b0, 1'b1);
      send_word(OP_V_MINUS_B, 16'h0000, 1'b0, 1'b0);
      send_word(OP_LIST_N, 16'hFFFF, 1'b1, 1'b1);
      send_word(OP_UNUSED, 16'hFFFF, 1'b1, 1'b1);
   endtask

   // Extreme keys along each insert path, then every query on the result:
   // 16'hFFFF and 16'h5A5A sit in both sets, 16'h0000 only in B.
   task automatic test_insert_extremes();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_word(OP_INSERT, 16'h0000, 1'b1, 1'b0);
      send_word(OP_INSERT, 16'hFFFF, 1'b0, 1'b1);
      send_word(OP_INSERT, 16'hFFFF, 1'b1, 1'b0);
      send_word(OP_INSERT, 16'h5A5A, 1'b1, 1'b1);
      send_word(OP_INSERT, 16'hA5A5, 1'b0, 1'b0);
      send_word(OP_LIST_B, 16'h0000, 1'b0, 1'b0);
      send_word(OP_LIST_V, 16'h0000, 1'b0, 1'b0);
      send_word(OP_PAIRS, 16'h0000, 1'b0, 1'b0);
      send_word(OP_B_MINUS_V, 16'h0000, 1'b0, 1'b0);
      send_word(OP_V_MINUS_B, 16'h0000, 1'b0, 1'b0);
      send_word(OP_LIST_N, 16'h0000, 1'b0, 1'b0);
   endtask

   // Fills the neither list to its depth, then one more insert gets dropped.
   task automatic test_full_neither();
      while (n_fill < LIST_DEPTH) send_word(OP_INSERT, KEY_W'($urandom), 1'b0, 1'b0);
      send_word(OP_INSERT, 16'h7FFF, 1'b0, 1'b0);
   endtask

   // B and V fill slowly from the key pool, with queries between inserts,
   // so that every query sees many partial states with shared keys.
   task automatic test_random_growth();
      key_pool[0] = 16'hFFFF;
      key_pool[1] = 16'h5A5A;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (140) send_random_word(20);
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while long queries keep
   // coming, so the output register fills and the block stalls its input.
   task automatic test_backpressure();
      tx_idle_on     = 1'b0;
      rx_idle_on     = 1'b0;
      rx_hold_cycles = 300;
      repeat (20)
         send_word(OP_W'($urandom_range(OP_LIST_B, OP_V_MINUS_B)), KEY_W'($urandom),
                   1'($urandom), 1'($urandom));
      wait_for_results();
   endtask

   // Short bursts, each followed by a pause until the block has answered all.
   task automatic test_drain_pause();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (4) begin
         repeat (10) send_random_word(25);
         wait_for_results();
      end
   endtask

   // Long random run on full lists; pacing changes every stretch, the first
   // stretch with no idling on either side.
   task automatic test_random_full();
      for (int s = 0; s < 8; s++) begin
         tx_idle_on = (s == 0) ? 1'b0 : 1'($urandom);
         rx_idle_on = (s == 0) ? 1'b0 : 1'($urandom);
         repeat (23) send_random_word(20);
      end
   endtask

   // The receiver draws a stall before each response word, or takes a hold
   // request from a test, then keeps ready high until a word is taken.
   initial begin : rsp_sink
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (rx_hold_cycles > 0) begin
            stall = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            stall = rx_idle_on ? $urandom_range(0, 12) : 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Every accepted response word is compared with the oldest owed word.
   always @(posedge clock) begin : rsp_check
      rsp_word_t want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         checked_words++;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("response word with none owed: value %h", rsp_chan.value));
         end else begin
            want = pending_words.pop_front();
            if (rsp_chan.value !== want.value)
               report_mismatch($sformatf("value %h, want %h", rsp_chan.value, want.value));
            if (rsp_chan.has_value !== want.has_value)
               report_mismatch($sformatf("has_value %b, want %b",
                                         rsp_chan.has_value, want.has_value));
            if (rsp_chan.final_flag !== want.final_flag)
               report_mismatch($sformatf("final_flag %b, want %b",
                                         rsp_chan.final_flag, want.final_flag));
            if (rsp_chan.full_res !== want.full_res)
               report_mismatch($sformatf("full_res %b, want %b",
                                         rsp_chan.full_res, want.full_res));
         end
      end
   end

   // Stops a hung run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Timeout with %0d response words still owed", pending_words.size());
      $display("Some tests failed");
      $finish;
   end

   // Main sequence: reset once, directed checks, then the random phases.
   initial begin : main_seq
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_INSERT;
      req_chan.roll    = '0;
      req_chan.likes_b = 1'b0;
      req_chan.likes_v = 1'b0;
      tx_idle_on       = 1'b0;
      rx_idle_on       = 1'b0;
      rx_hold_cycles   = 0;
      mismatch_count   = 0;
      sent_words       = 0;
      checked_words    = 0;
      drop_count       = 0;
      b_fill           = 0;
      v_fill           = 0;
      n_fill           = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (key_pool[i]) key_pool[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_lists();
      test_insert_extremes();
      test_full_neither();
      test_random_growth();
      test_backpressure();
      test_drain_pause();
      test_random_full();

      // Let the longest scan finish so that any stray word still shows up.
      wait_for_results();
      repeat (LIST_DEPTH * LIST_DEPTH + 8) @(posedge clock);

      $display("Sent %0d words (%0d inserts, %0d dropped by a full list), checked %0d results.",
               sent_words, op_seen[OP_INSERT], drop_count, checked_words);
      $display("Queries: B %0d, V %0d, pairs %0d, B-V %0d, V-B %0d, neither %0d, unused %0d.",
               op_seen[OP_LIST_B], op_seen[OP_LIST_V], op_seen[OP_PAIRS],
               op_seen[OP_B_MINUS_V], op_seen[OP_V_MINUS_B], op_seen[OP_LIST_N],
               op_seen[OP_UNUSED]);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
